[sv/cartridge_bank_mapper_assert.svh]
// Assertion macros for the cartridge bank mapper.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef CARTRIDGE_BANK_MAPPER_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define CBM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cartridge_bank_mapper: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define CBM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cartridge_bank_mapper: next-cycle check failed");
`else
`define CBM_ASSERT_SAME(lbl, ante, cons)
`define CBM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/cbm_pkg.sv]
// Shared types and constants for the cartridge bank mapper.
// No dependencies; used by cbm_regs, cbm_map and cartridge_bank_mapper.
package cbm_pkg;

    localparam int ROM_ADDR_BITS = 21;
    localparam int RAM_ADDR_BITS = 16;

    localparam int ROM_FIELD_W = 21;
    localparam int RAM_FIELD_W = 16;
    localparam int RAM_OFF_W   = 21;
    localparam int CFG_IDX_W   = 2;

    localparam logic [4:0] ROM_BASE_BITS = 5'd15;
    localparam logic [4:0] BIG_ROM_BITS  = 5'd19;

    localparam logic [7:0] MBC1_LO = 8'h01;
    localparam logic [7:0] MBC1_HI = 8'h03;
    localparam logic [7:0] MBC3_LO = 8'h0F;
    localparam logic [7:0] MBC3_HI = 8'h13;

    localparam logic [3:0] RAM_EN_KEY    = 4'hA;
    localparam logic [6:0] MBC1_BANK_MSK = 7'h1F;
    localparam logic [6:0] MBC3_BANK_MSK = 7'h7F;
    localparam logic [6:0] ROM_BANK_RST  = 7'd1;
    localparam logic [7:0] MBC3_RTC_SEL  = 8'h08;
    localparam logic [7:0] BYTE_OPEN     = 8'hFF;
    localparam logic [7:0] BYTE_ZERO     = 8'h00;

    // opcodes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // result targets
    localparam logic [1:0] TGT_ROM   = 2'd0;
    localparam logic [1:0] TGT_RAM   = 2'd1;
    localparam logic [1:0] TGT_FIXED = 2'd2;

    // RAM window lookup outcome
    localparam logic [1:0] LOC_OK   = 2'd0;
    localparam logic [1:0] LOC_OPEN = 2'd1;
    localparam logic [1:0] LOC_ZERO = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CART_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROM_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAM_SIZE  = 2'd2;

    // mapper register select, bus_address[14:13] within 0x0000-0x7FFF
    localparam logic [1:0] SEL_RAM_EN   = 2'd0;
    localparam logic [1:0] SEL_ROM_BANK = 2'd1;
    localparam logic [1:0] SEL_RAM_BANK = 2'd2;
    localparam logic [1:0] SEL_MODE     = 2'd3;

    typedef struct packed {
        logic [7:0] cart_type;
        logic [2:0] rom_size_code;
        logic [2:0] ram_size_sel;
    } cfg_t;

    typedef struct packed {
        logic       ram_enable;
        logic [6:0] rom_bank;
        logic [7:0] ram_bank;
        logic       bank_mode;
    } state_t;

    typedef struct packed {
        logic        opcode;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } item_t;

    typedef struct packed {
        logic [1:0]             target;
        logic [ROM_FIELD_W-1:0] rom_address;
        logic [RAM_FIELD_W-1:0] ram_address;
        logic [7:0]             fixed_byte;
        logic                   ram_write;
        logic                   handled;
    } result_t;

    typedef struct packed {
        logic   we;
        state_t nxt;
    } state_upd_t;

endpackage

[sv/cbm_regs.sv]
// Configuration and bank state registers of the cartridge bank mapper.
// Depends on cbm_pkg.
module cbm_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data,
    input  cbm_pkg::state_upd_t            upd,
    output cbm_pkg::cfg_t                  cfg,
    output cbm_pkg::state_t                st
);

    cbm_pkg::cfg_t   cfg_reg;
    cbm_pkg::cfg_t   cfg_next;
    cbm_pkg::state_t st_reg;
    cbm_pkg::state_t st_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                cbm_pkg::REG_CART_TYPE: cfg_next.cart_type     = cfg_data;
                cbm_pkg::REG_ROM_SIZE:  cfg_next.rom_size_code = cfg_data[2:0];
                cbm_pkg::REG_RAM_SIZE:  cfg_next.ram_size_sel  = cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        st_next = st_reg;
        if (upd.we)
        begin
            st_next = upd.nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
            st_reg  <= '{ram_enable: 1'b0, rom_bank: cbm_pkg::ROM_BANK_RST,
                         ram_bank: 8'd0, bank_mode: 1'b0};
        end
        else
        begin
            cfg_reg <= cfg_next;
            st_reg  <= st_next;
        end
    end

    assign cfg = cfg_reg;
    assign st  = st_reg;

endmodule

[sv/cbm_map.sv]
// Address decode and bank mapping for one bus access.
// Depends on cbm_pkg; pure combinational logic fed by the input register.
module cbm_map
(
    input  cbm_pkg::item_t      item,
    input  cbm_pkg::cfg_t       cfg,
    input  cbm_pkg::state_t     st,
    output cbm_pkg::result_t    res,
    output cbm_pkg::state_upd_t upd
);

    logic                                is_mbc1;
    logic                                is_mbc3;
    logic                                in_rom;
    logic                                in_ram;
    logic                                big;
    logic [4:0]                          rom_bits;
    logic [cbm_pkg::ROM_FIELD_W-1:0]     rom_mask;
    logic [cbm_pkg::ROM_FIELD_W-1:0]     rom_off;
    logic [6:0]                          hi_bank;
    logic                                has_ram;
    logic [4:0]                          ram_bits_raw;
    logic [4:0]                          ram_bits;
    logic [7:0]                          sel_bank;
    logic [cbm_pkg::RAM_OFF_W-1:0]       ram_off;
    logic                                ram_fits;
    logic [1:0]                          loc;
    logic [6:0]                          new_rom_bank;

    assign is_mbc1 = cfg.cart_type inside {[cbm_pkg::MBC1_LO:cbm_pkg::MBC1_HI]};
    assign is_mbc3 = cfg.cart_type inside {[cbm_pkg::MBC3_LO:cbm_pkg::MBC3_HI]};
    assign in_rom  = ~item.bus_address[15];
    assign in_ram  = (item.bus_address[15:13] == 3'b101);

    // ROM side: window width saturates at the ROM address field
    always_comb
    begin
        rom_bits = cbm_pkg::ROM_BASE_BITS + {2'b00, cfg.rom_size_code};
        if (rom_bits > 5'(cbm_pkg::ROM_ADDR_BITS))
        begin
            rom_bits = 5'(cbm_pkg::ROM_ADDR_BITS);
        end
        for (int i = 0; i < cbm_pkg::ROM_FIELD_W; i++)
        begin
            rom_mask[i] = (5'(i) < rom_bits);
        end
    end

    assign big     = (rom_bits > cbm_pkg::BIG_ROM_BITS);
    // upper ROM bank bits come from the RAM bank register on large MBC1 carts
    assign hi_bank = big ? {st.ram_bank[1:0], 5'b00000} : 7'd0;

    always_comb
    begin
        if (!item.bus_address[14])
        begin
            if (is_mbc1 && st.bank_mode)
            begin
                rom_off = {hi_bank, item.bus_address[13:0]};
            end
            else
            begin
                rom_off = {7'd0, item.bus_address[13:0]};
            end
        end
        else if (is_mbc1)
        begin
            rom_off = {st.rom_bank | hi_bank, item.bus_address[13:0]};
        end
        else if (is_mbc3)
        begin
            rom_off = {st.rom_bank, item.bus_address[13:0]};
        end
        else
        begin
            rom_off = {6'd0, item.bus_address[14:0]};
        end
    end

    // RAM side
    always_comb
    begin
        has_ram = 1'b1;
        case (cfg.ram_size_sel)
            3'd2:    ram_bits_raw = 5'd13;
            3'd3:    ram_bits_raw = 5'd15;
            3'd4:    ram_bits_raw = 5'd17;
            3'd5:    ram_bits_raw = 5'd16;
            default:
            begin
                ram_bits_raw = 5'd0;
                has_ram      = 1'b0;
            end
        endcase
        ram_bits = ram_bits_raw;
        if (ram_bits_raw > 5'(cbm_pkg::RAM_ADDR_BITS))
        begin
            ram_bits = 5'(cbm_pkg::RAM_ADDR_BITS);
        end
    end

    assign sel_bank = (st.bank_mode || is_mbc3) ? st.ram_bank : 8'd0;
    assign ram_off  = {sel_bank, item.bus_address[12:0]};
    assign ram_fits = ((ram_off >> ram_bits) == '0);

    always_comb
    begin
        if (!st.ram_enable)
        begin
            loc = cbm_pkg::LOC_OPEN;
        end
        else if (is_mbc3 && (st.ram_bank >= cbm_pkg::MBC3_RTC_SEL))
        begin
            loc = cbm_pkg::LOC_ZERO;
        end
        else if (!has_ram || !ram_fits)
        begin
            loc = cbm_pkg::LOC_OPEN;
        end
        else
        begin
            loc = cbm_pkg::LOC_OK;
        end
    end

    always_comb
    begin
        new_rom_bank = item.write_data[6:0]
                       & (is_mbc1 ? cbm_pkg::MBC1_BANK_MSK : cbm_pkg::MBC3_BANK_MSK);
        if (new_rom_bank == 7'd0)
        begin
            new_rom_bank = cbm_pkg::ROM_BANK_RST;
        end
    end

    always_comb
    begin
        res.target      = cbm_pkg::TGT_FIXED;
        res.rom_address = '0;
        res.ram_address = '0;
        res.fixed_byte  = cbm_pkg::BYTE_ZERO;
        res.ram_write   = 1'b0;
        res.handled     = 1'b0;
        upd.we          = 1'b0;
        upd.nxt         = st;

        if (item.opcode == cbm_pkg::OP_READ)
        begin
            res.fixed_byte = cbm_pkg::BYTE_OPEN;
            if (in_rom)
            begin
                res.target      = cbm_pkg::TGT_ROM;
                res.rom_address = rom_off & rom_mask;
                res.fixed_byte  = cbm_pkg::BYTE_ZERO;
            end
            else if (in_ram)
            begin
                if (loc == cbm_pkg::LOC_OK)
                begin
                    res.target      = cbm_pkg::TGT_RAM;
                    res.ram_address = ram_off[cbm_pkg::RAM_FIELD_W-1:0];
                    res.fixed_byte  = cbm_pkg::BYTE_ZERO;
                end
                else if (loc == cbm_pkg::LOC_ZERO)
                begin
                    res.fixed_byte = cbm_pkg::BYTE_ZERO;
                end
            end
        end
        else if (in_rom && (is_mbc1 || is_mbc3))
        begin
            res.handled = 1'b1;
            upd.we      = 1'b1;
            case (item.bus_address[14:13])
                cbm_pkg::SEL_RAM_EN:
                    upd.nxt.ram_enable = (item.write_data[3:0] == cbm_pkg::RAM_EN_KEY);
                cbm_pkg::SEL_ROM_BANK:
                    upd.nxt.rom_bank = new_rom_bank;
                cbm_pkg::SEL_RAM_BANK:
                    upd.nxt.ram_bank = is_mbc1 ? {6'd0, item.write_data[1:0]}
                                               : item.write_data;
                cbm_pkg::SEL_MODE:
                begin
                    if (is_mbc1)
                    begin
                        upd.nxt.bank_mode = item.write_data[0];
                    end
                end
                default: ;
            endcase
        end
        else if (in_ram)
        begin
            // dropped RAM writes still count as handled
            res.handled = 1'b1;
            if (loc == cbm_pkg::LOC_OK)
            begin
                res.target      = cbm_pkg::TGT_RAM;
                res.ram_address = ram_off[cbm_pkg::RAM_FIELD_W-1:0];
                res.ram_write   = 1'b1;
            end
        end
    end

endmodule

[sv/cartridge_bank_mapper.sv]
// Cartridge bank mapper (MBC1 / MBC3): accepted items are decoded, then registered.
// One item per cycle when not stalled: input register, one decode pass, result register.
// A stalled result holds; the input stalls only while both registers are full and stalled.
// Mapper registers written by an item are seen by the very next item.
// Reset clears both valid flags and all config registers, disables RAM, sets ROM bank 1.
// Config writes are always ready and take effect at the next clock edge.
module cartridge_bank_mapper
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [7:0]                           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 opcode,
    input  logic [15:0]                          bus_address,
    input  logic [7:0]                           write_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           target,
    output logic [cbm_pkg::ROM_FIELD_W-1:0]      rom_address,
    output logic [cbm_pkg::RAM_FIELD_W-1:0]      ram_address,
    output logic [7:0]                           fixed_byte,
    output logic                                 ram_write,
    output logic                                 handled
);

`include "cartridge_bank_mapper_assert.svh"

    logic                in_valid_reg;
    logic                in_valid_next;
    cbm_pkg::item_t      item_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    cbm_pkg::result_t    res_reg;
    cbm_pkg::result_t    res_comb;
    cbm_pkg::state_upd_t upd_comb;
    cbm_pkg::state_upd_t upd_gated;
    cbm_pkg::cfg_t       cfg;
    cbm_pkg::state_t     st;
    logic                advance;
    logic                fire;
    logic                accept;

    assign cfg_ready = 1'b1;

    // result register can take a new item when empty or being drained
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign fire     = in_valid_reg && advance;

    assign upd_gated.we  = upd_comb.we && fire;
    assign upd_gated.nxt = upd_comb.nxt;

    cbm_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .upd       (upd_gated),
        .cfg       (cfg),
        .st        (st)
    );

    cbm_map u_map
    (
        .item (item_reg),
        .cfg  (cfg),
        .st   (st),
        .res  (res_comb),
        .upd  (upd_comb)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= '{opcode: opcode, bus_address: bus_address, write_data: write_data};
        end
        if (fire)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid   = out_valid_reg;
    assign target      = res_reg.target;
    assign rom_address = res_reg.rom_address;
    assign ram_address = res_reg.ram_address;
    assign fixed_byte  = res_reg.fixed_byte;
    assign ram_write   = res_reg.ram_write;
    assign handled     = res_reg.handled;

    `CBM_ASSERT_SAME(a_ram_write_target, out_valid && ram_write, (target == cbm_pkg::TGT_RAM) && handled)
    `CBM_ASSERT_SAME(a_fixed_only_when_fixed, out_valid && (target != cbm_pkg::TGT_FIXED), fixed_byte == cbm_pkg::BYTE_ZERO)
    `CBM_ASSERT_SAME(a_rom_bank_nonzero, 1'b1, st.rom_bank != 7'd0)
    `CBM_ASSERT_SAME(a_stall_from_output, in_stall, out_valid && out_stall)

endmodule
